// ===== src/jsu_pkg.sv =====
`default_nettype none
package jsu_pkg;

  localparam int unsigned MaxResults = 3;
  localparam int unsigned CntW = 2;

  localparam logic [2:0] MODE_NORMAL = 3'd0;
  localparam logic [2:0] MODE_ESCAPE = 3'd1;
  localparam logic [2:0] MODE_HEX1 = 3'd2;
  localparam logic [2:0] MODE_HEX4 = 3'd5;

  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_B = 8'h62;
  localparam logic [7:0] CH_F = 8'h66;
  localparam logic [7:0] CH_N = 8'h6E;
  localparam logic [7:0] CH_R = 8'h72;
  localparam logic [7:0] CH_T = 8'h74;
  localparam logic [7:0] CH_U = 8'h75;

  typedef struct packed {
    logic [7:0] data;
    logic       has;
    logic       fin;
    logic       lst;
  } res_t;

  typedef struct packed {
    logic            ok;
    logic [3:0]      val;
  } hex_t;

  typedef struct packed {
    logic [CntW-1:0] cnt;
    logic [2:0][7:0] b;
  } utf8_t;

  function automatic hex_t hex_digit(input logic [7:0] c);
    hex_t h;
    h.ok = 1'b1;
    h.val = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.val = 4'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      h.val = 4'(c - 8'h57);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      h.val = 4'(c - 8'h37);
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

  function automatic utf8_t utf8_encode(input logic [15:0] cp);
    utf8_t u;
    u.b = '0;
    if (cp < 16'h0080) begin
      u.cnt = 2'd1;
      u.b[0] = cp[7:0];
    end else if (cp < 16'h0800) begin
      u.cnt = 2'd2;
      u.b[0] = 8'hC0 | {3'b000, cp[10:6]};
      u.b[1] = 8'h80 | {2'b00, cp[5:0]};
    end else begin
      u.cnt = 2'd3;
      u.b[0] = 8'hE0 | {4'b0000, cp[15:12]};
      u.b[1] = 8'h80 | {2'b00, cp[11:6]};
      u.b[2] = 8'h80 | {2'b00, cp[5:0]};
    end
    return u;
  endfunction

endpackage
`default_nettype wire

// ===== src/json_string_unescape.sv =====
// JSON string body unescaper producing UTF-8.
// Input channel: in_valid/in_stall carry in_char, one raw byte of a string
// body per transfer, starting after the opening quote.
// Output channel: out_valid/out_stall carry out_byte, out_has_byte,
// out_string_end and out_last; one input byte yields zero to three results,
// and out_last marks the final result of that byte.
// Each accepted byte is decoded in its acceptance cycle into a result
// register, so its first result appears in the next cycle.
// One byte is taken per cycle while its results fit in one output transfer
// and the receiver does not stall; a byte that yields two or three UTF-8
// bytes stalls the input while the result register drains, one result per
// cycle unless stalled; the next byte is taken as its last result leaves.
// A backslash and hex digits before the last yield no result.
// When the receiver stalls, the current result holds and the input is
// stalled while the result register holds any result.
// Reset empties the result register and returns the decoder to normal mode.
`default_nettype none
module json_string_unescape (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_char,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_byte,
  output logic            out_has_byte,
  output logic            out_string_end,
  output logic            out_last
);

  logic [2:0]                 mode_r, mode_nxt;
  logic [15:0]                hex_r, hex_nxt;
  logic                       stop_r, stop_nxt;
  logic [jsu_pkg::CntW-1:0]   cnt_r, cnt_nxt;
  jsu_pkg::res_t              res_r [jsu_pkg::MaxResults];
  jsu_pkg::res_t              dec_res [jsu_pkg::MaxResults];
  logic [jsu_pkg::CntW-1:0]   dec_cnt;
  logic                       load, pop;
  jsu_pkg::hex_t              hd;
  jsu_pkg::utf8_t             u8;
  logic [15:0]                cp;
  logic                       cp_end;

  assign out_valid = (cnt_r != '0);
  assign pop = out_valid && !out_stall;
  assign in_stall = !((cnt_r == '0) || ((cnt_r == jsu_pkg::CntW'(1)) && !out_stall));
  assign load = in_valid && !in_stall;

  assign out_byte = res_r[0].data;
  assign out_has_byte = res_r[0].has;
  assign out_string_end = res_r[0].fin;
  assign out_last = res_r[0].lst;

  always_comb begin
    hd = jsu_pkg::hex_digit(in_char);
    mode_nxt = mode_r;
    hex_nxt = hex_r;
    stop_nxt = stop_r;
    dec_cnt = '0;
    cp = '0;
    cp_end = 1'b0;
    u8 = '0;
    for (int i = 0; i < jsu_pkg::MaxResults; i++) begin
      dec_res[i] = '0;
    end

    if (mode_r == jsu_pkg::MODE_ESCAPE) begin
      mode_nxt = jsu_pkg::MODE_NORMAL;
      dec_cnt = jsu_pkg::CntW'(1);
      dec_res[0].has = 1'b1;
      dec_res[0].lst = 1'b1;
      case (in_char)
        jsu_pkg::CH_NUL: begin
          dec_res[0].has = 1'b0;
          dec_res[0].fin = 1'b1;
        end
        jsu_pkg::CH_QUOTE:  dec_res[0].data = jsu_pkg::CH_QUOTE;
        jsu_pkg::CH_BSLASH: dec_res[0].data = jsu_pkg::CH_BSLASH;
        jsu_pkg::CH_SLASH:  dec_res[0].data = jsu_pkg::CH_SLASH;
        jsu_pkg::CH_B:      dec_res[0].data = 8'h08;
        jsu_pkg::CH_F:      dec_res[0].data = 8'h0C;
        jsu_pkg::CH_N:      dec_res[0].data = 8'h0A;
        jsu_pkg::CH_R:      dec_res[0].data = 8'h0D;
        jsu_pkg::CH_T:      dec_res[0].data = 8'h09;
        jsu_pkg::CH_U: begin
          dec_cnt = '0;
          mode_nxt = jsu_pkg::MODE_HEX1;
          hex_nxt = '0;
          stop_nxt = 1'b0;
        end
        default: dec_cnt = '0;
      endcase
    end else if (mode_r >= jsu_pkg::MODE_HEX1 && mode_r <= jsu_pkg::MODE_HEX4) begin
      cp = hex_r;
      if (in_char == jsu_pkg::CH_NUL || !hd.ok) begin
        stop_nxt = 1'b1;
      end else if (!stop_r) begin
        cp = {hex_r[11:0], hd.val};
      end
      hex_nxt = cp;
      mode_nxt = mode_r + 3'd1;
      if (in_char == jsu_pkg::CH_NUL || mode_r == jsu_pkg::MODE_HEX4) begin
        cp_end = (in_char == jsu_pkg::CH_NUL);
        mode_nxt = jsu_pkg::MODE_NORMAL;
        hex_nxt = '0;
        stop_nxt = 1'b0;
        u8 = jsu_pkg::utf8_encode(cp);
        dec_cnt = u8.cnt;
        for (int i = 0; i < jsu_pkg::MaxResults; i++) begin
          dec_res[i].data = u8.b[i];
          dec_res[i].has = 1'b1;
          dec_res[i].lst = (jsu_pkg::CntW'(i + 1) == u8.cnt);
          dec_res[i].fin = cp_end && (jsu_pkg::CntW'(i + 1) == u8.cnt);
        end
      end
    end else begin
      mode_nxt = jsu_pkg::MODE_NORMAL;
      if (in_char == jsu_pkg::CH_NUL || in_char == jsu_pkg::CH_QUOTE) begin
        dec_cnt = jsu_pkg::CntW'(1);
        dec_res[0].fin = 1'b1;
        dec_res[0].lst = 1'b1;
      end else if (in_char == jsu_pkg::CH_BSLASH) begin
        mode_nxt = jsu_pkg::MODE_ESCAPE;
      end else begin
        dec_cnt = jsu_pkg::CntW'(1);
        dec_res[0].data = in_char;
        dec_res[0].has = 1'b1;
        dec_res[0].lst = 1'b1;
      end
    end
  end

  assign cnt_nxt = load ? dec_cnt : (cnt_r - jsu_pkg::CntW'(pop));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= jsu_pkg::MODE_NORMAL;
      hex_r <= '0;
      stop_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (load) begin
        mode_r <= mode_nxt;
        hex_r <= hex_nxt;
        stop_r <= stop_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      for (int i = 0; i < jsu_pkg::MaxResults; i++) begin
        res_r[i] <= dec_res[i];
      end
    end else if (pop) begin
      for (int i = 0; i < jsu_pkg::MaxResults - 1; i++) begin
        res_r[i] <= res_r[i+1];
      end
    end
  end

endmodule
`default_nettype wire
